// ===== hw/rtl/rmsu_pkg.sv =====
// ----------------------------------------------------------------------------
// rmsu_pkg
// Types and constants shared by the stages of the ring Metropolis site update.
// ----------------------------------------------------------------------------
package rmsu_pkg;

    localparam int unsigned NB_COUNT = 6;
    localparam int unsigned VAL_W    = 8;
    localparam int unsigned SUM_W    = 10;

    localparam logic [VAL_W-1:0] IDX_MAX = 8'hFF;

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_LOAD   = 1'b1;

    // One request as it arrives on the input stream.
    typedef struct packed {
        logic                               kind;
        logic [VAL_W-1:0]                   old_value;
        logic [NB_COUNT-1:0][VAL_W-1:0]     nb;
        logic [VAL_W-1:0]                   proposal;
        logic [VAL_W-1:0]                   chance;
        logic [VAL_W-1:0]                   table_address;
        logic [VAL_W-1:0]                   table_data;
    } t_item;

    // After the distance stage.
    typedef struct packed {
        logic                               kind;
        logic [VAL_W-1:0]                   old_value;
        logic [VAL_W-1:0]                   cand;
        logic [VAL_W-1:0]                   chance;
        logic [VAL_W-1:0]                   table_address;
        logic [VAL_W-1:0]                   table_data;
        logic [NB_COUNT-1:0][VAL_W-1:0]     dist_old;
        logic [NB_COUNT-1:0][VAL_W-1:0]     dist_new;
    } t_s1;

    // After the sum stage.
    typedef struct packed {
        logic                               kind;
        logic [VAL_W-1:0]                   old_value;
        logic [VAL_W-1:0]                   cand;
        logic [VAL_W-1:0]                   chance;
        logic [VAL_W-1:0]                   table_address;
        logic [VAL_W-1:0]                   table_data;
        logic [SUM_W-1:0]                   sum_old;
        logic [SUM_W-1:0]                   sum_new;
    } t_s2;

    // After the table stage; only update requests get here.
    typedef struct packed {
        logic [VAL_W-1:0]                   old_value;
        logic [VAL_W-1:0]                   cand;
        logic [VAL_W-1:0]                   chance;
        logic                               non_pos;
        logic [VAL_W-1:0]                   threshold;
    } t_s3;

endpackage

// ===== hw/rtl/rmsu_dist_stage.sv =====
// ----------------------------------------------------------------------------
// rmsu_dist_stage
// Forms the candidate and the twelve circular neighbor distances.
// ----------------------------------------------------------------------------
module rmsu_dist_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  rmsu_pkg::t_item i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output rmsu_pkg::t_s1   o_data
);

    logic                  r_valid;
    rmsu_pkg::t_s1         r_data;
    rmsu_pkg::t_s1         n_data;
    logic                  w_load;

    // Distance on a ring of 256: min(d, 256 - d) with d = x - n wrapped.
    function automatic logic [rmsu_pkg::VAL_W-1:0] ring_dist(
        input logic [rmsu_pkg::VAL_W-1:0] x,
        input logic [rmsu_pkg::VAL_W-1:0] n
    );
        logic [rmsu_pkg::VAL_W-1:0] d;
        d = x - n;
        if (d[rmsu_pkg::VAL_W-1] && (d[rmsu_pkg::VAL_W-2:0] != '0)) begin
            ring_dist = -d;
        end else begin
            ring_dist = d;
        end
    endfunction

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    always_comb begin
        n_data               = '0;
        n_data.kind          = i_data.kind;
        n_data.old_value     = i_data.old_value;
        n_data.cand          = i_data.old_value + i_data.proposal;
        n_data.chance        = i_data.chance;
        n_data.table_address = i_data.table_address;
        n_data.table_data    = i_data.table_data;
        for (int i = 0; i < rmsu_pkg::NB_COUNT; i++) begin
            n_data.dist_old[i] = ring_dist(i_data.old_value, i_data.nb[i]);
            n_data.dist_new[i] = ring_dist(n_data.cand, i_data.nb[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hw/rtl/rmsu_sum_stage.sv =====
// ----------------------------------------------------------------------------
// rmsu_sum_stage
// Adds the six distances for the old value and for the candidate.
// ----------------------------------------------------------------------------
module rmsu_sum_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  rmsu_pkg::t_s1   i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output rmsu_pkg::t_s2   o_data
);

    logic                  r_valid;
    rmsu_pkg::t_s2         r_data;
    rmsu_pkg::t_s2         n_data;
    logic                  w_load;

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    always_comb begin
        n_data               = '0;
        n_data.kind          = i_data.kind;
        n_data.old_value     = i_data.old_value;
        n_data.cand          = i_data.cand;
        n_data.chance        = i_data.chance;
        n_data.table_address = i_data.table_address;
        n_data.table_data    = i_data.table_data;
        for (int i = 0; i < rmsu_pkg::NB_COUNT; i++) begin
            n_data.sum_old = n_data.sum_old + rmsu_pkg::SUM_W'(i_data.dist_old[i]);
            n_data.sum_new = n_data.sum_new + rmsu_pkg::SUM_W'(i_data.dist_new[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hw/rtl/rmsu_table_stage.sv =====
// ----------------------------------------------------------------------------
// rmsu_table_stage
// Holds the acceptance table. Load requests write it here and end; update
// requests read the entry picked by the clamped action change.
// ----------------------------------------------------------------------------
module rmsu_table_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  rmsu_pkg::t_s2   i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output rmsu_pkg::t_s3   o_data
);

    localparam int unsigned TABLE_DEPTH = 1 << rmsu_pkg::VAL_W;

    logic [rmsu_pkg::VAL_W-1:0] r_table [TABLE_DEPTH];

    logic                        r_valid;
    rmsu_pkg::t_s3               r_data;
    logic                        w_load;
    logic                        w_is_load;
    logic                        w_non_pos;
    logic [rmsu_pkg::SUM_W-1:0]  w_diff;
    logic [rmsu_pkg::VAL_W-1:0]  w_idx;

    assign o_ready   = !r_valid || i_ready;
    assign w_load    = i_valid && o_ready;
    assign w_is_load = (i_data.kind == rmsu_pkg::KIND_LOAD);

    // The difference is only used when it is positive, so the wrap does no harm.
    assign w_non_pos = (i_data.sum_new <= i_data.sum_old);
    assign w_diff    = i_data.sum_new - i_data.sum_old;
    assign w_idx     = (w_diff[rmsu_pkg::SUM_W-1:rmsu_pkg::VAL_W] != '0)
                     ? rmsu_pkg::IDX_MAX : w_diff[rmsu_pkg::VAL_W-1:0];

    // Writes and reads happen at the same stage, so table order follows
    // request order.
    always_ff @(posedge i_clk) begin
        if (w_load && w_is_load) begin
            r_table[i_data.table_address] <= i_data.table_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data.threshold <= r_table[w_idx];
            r_data.old_value <= i_data.old_value;
            r_data.cand      <= i_data.cand;
            r_data.chance    <= i_data.chance;
            r_data.non_pos   <= w_non_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid && !w_is_load;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hw/rtl/ring_metropolis_site_update_core.sv =====
// Pipeline: four register stages (distance, sum, table, output); an update's
// result is registered in each in turn and can stall in any of them.
// Throughput: one request per cycle unless the output stream stalls; a load
// request ends in the table stage; back-pressure on m_axis_tready sets the rate.
// Reset: synchronous, active low; clears the valid bits of every stage.
// The acceptance table is not cleared; entries must be loaded before use.
// ----------------------------------------------------------------------------
// ring_metropolis_site_update_core
// Metropolis accept/reject of one ring-valued lattice site per request.
// ----------------------------------------------------------------------------
module ring_metropolis_site_update_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // old_value, right_value, left_value, up_value, down_value, front_value,
    // back_value, proposal, chance, table_address, table_data (8 bits each)
    input  logic [87:0] s_axis_tdata,
    // kind
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // new_value [7:0], accepted [8], zero [15:9]
    output logic [15:0] m_axis_tdata
);

    localparam int unsigned W = rmsu_pkg::VAL_W;

    rmsu_pkg::t_item  w_item;
    rmsu_pkg::t_s1    w_s1;
    rmsu_pkg::t_s2    w_s2;
    rmsu_pkg::t_s3    w_s3;
    logic             w_v1;
    logic             w_v2;
    logic             w_v3;
    logic             w_rdy1;
    logic             w_rdy2;
    logic             w_rdy3;
    logic             w_rdy_out;
    logic             w_take;

    logic             r_m_valid;
    logic [W-1:0]     r_new_value;
    logic             r_accepted;

    always_comb begin
        w_item               = '0;
        w_item.kind          = s_axis_tuser;
        w_item.old_value     = s_axis_tdata[W-1:0];
        for (int i = 0; i < rmsu_pkg::NB_COUNT; i++) begin
            w_item.nb[i] = s_axis_tdata[(i+1)*W +: W];
        end
        w_item.proposal      = s_axis_tdata[7*W +: W];
        w_item.chance        = s_axis_tdata[8*W +: W];
        w_item.table_address = s_axis_tdata[9*W +: W];
        w_item.table_data    = s_axis_tdata[10*W +: W];
    end

    rmsu_dist_stage u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (w_item),
        .o_valid (w_v1),
        .i_ready (w_rdy1),
        .o_data  (w_s1)
    );

    rmsu_sum_stage u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v1),
        .o_ready (w_rdy1),
        .i_data  (w_s1),
        .o_valid (w_v2),
        .i_ready (w_rdy2),
        .o_data  (w_s2)
    );

    rmsu_table_stage u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v2),
        .o_ready (w_rdy2),
        .i_data  (w_s2),
        .o_valid (w_v3),
        .i_ready (w_rdy3),
        .o_data  (w_s3)
    );

    // Output register: final compare against the table threshold.
    assign w_rdy_out = !r_m_valid || m_axis_tready;
    assign w_rdy3    = w_rdy_out;
    assign w_take    = w_s3.non_pos || (w_s3.chance < w_s3.threshold);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_rdy_out) begin
            r_m_valid <= w_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_v3 && w_rdy_out) begin
            r_new_value <= w_take ? w_s3.cand : w_s3.old_value;
            r_accepted  <= w_take;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {7'b0, r_accepted, r_new_value};

`ifndef NO_ASSERTIONS
    // With the output register empty, every stage has room for a request.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_m_valid |-> s_axis_tready)
        else $error("input stalled while the output register is empty");

    // A load request leaving the sum stage must not occupy the table stage's output.
    a_load_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_v2 && (w_s2.kind == rmsu_pkg::KIND_LOAD) && w_rdy2) |=> !w_v3)
        else $error("load request produced a result slot");

    // A non-positive action change is always accepted.
    a_non_pos_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_v3 && w_rdy3 && w_s3.non_pos) |=> (m_axis_tvalid && m_axis_tdata[W]))
        else $error("non-positive action change was rejected");
`endif

endmodule

// ===== tb/ring_metropolis_site_update_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ring_metropolis_site_update_core_test
// Streams table loads and site updates into the core. Each update's outcome is
// predicted when the core takes the request, and every output beat is checked in
// order against them; both streams idle at random but in the full-rate phase.
// ----------------------------------------------------------------------------
module ring_metropolis_site_update_core_test;

    localparam int IDLE_LIMIT = 1000;
    localparam int TAIL_CYCLES = 8;

    typedef struct packed {
        logic                                             kind;
        logic [rmsu_pkg::VAL_W-1:0]                       old_value;
        // right, left, up, down, front, back
        logic [rmsu_pkg::NB_COUNT-1:0][rmsu_pkg::VAL_W-1:0] nb;
        logic [rmsu_pkg::VAL_W-1:0]                       proposal;
        logic [rmsu_pkg::VAL_W-1:0]                       chance;
        logic [rmsu_pkg::VAL_W-1:0]                       tab_addr;
        logic [rmsu_pkg::VAL_W-1:0]                       tab_data;
    } t_site_req;

    typedef struct packed {
        logic [rmsu_pkg::VAL_W-1:0] new_value;
        logic                       accepted;
    } t_site_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // old_value, right, left, up, down, front, back, proposal, chance,
    // table_address, table_data (8 bits each, from the lowest bit up)
    logic [87:0] s_axis_tdata = '0;
    // kind
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // new_value [7:0], accepted [8], zero [15:9]
    logic [15:0] m_axis_tdata;

    logic [rmsu_pkg::VAL_W-1:0] accept_thresh [0:255];
    bit                         thresh_loaded [0:255];
    t_site_res                  pending_sites [$];
    int                         error_count = 0;
    int                         idle_cycles = 0;
    int                         rx_hold = 0;
    bit                         tx_idle_on = 1'b1;
    bit                         rx_stall_on = 1'b1;

    ring_metropolis_site_update_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // Sum of circular distances from x to the six neighbors.
    function automatic logic [9:0] ring_cost(
        input logic [rmsu_pkg::VAL_W-1:0] x,
        input logic [rmsu_pkg::NB_COUNT-1:0][rmsu_pkg::VAL_W-1:0] nbs
    );
        logic [rmsu_pkg::VAL_W-1:0] d;
        logic [rmsu_pkg::VAL_W:0]   e;
        logic [9:0]                 s;
        s = '0;
        for (int i = 0; i < rmsu_pkg::NB_COUNT; i++) begin
            d = x - nbs[i];
            e = 9'd256 - d;
            s = s + ((d < e) ? d : e);
        end
        return s;
    endfunction

    // Table index the move would read, or zero when it is downhill or flat.
    // The action change is always even, so odd entries below 255 are never read.
    function automatic logic [7:0] uphill_index(input t_site_req r);
        logic [rmsu_pkg::VAL_W-1:0] cand;
        logic [9:0]                 s_old;
        logic [9:0]                 s_new;
        logic [9:0]                 diff;
        cand = r.old_value + r.proposal;
        s_old = ring_cost(r.old_value, r.nb);
        s_new = ring_cost(cand, r.nb);
        if (s_new <= s_old) return 8'd0;
        diff = s_new - s_old;
        if (diff > 10'(rmsu_pkg::IDX_MAX)) return rmsu_pkg::IDX_MAX;
        return diff[7:0];
    endfunction

    function automatic t_site_res metropolis_decide(input t_site_req r);
        t_site_res   res;
        logic [7:0]  idx;
        idx = uphill_index(r);
        res.accepted = (idx == 8'd0) || (r.chance < accept_thresh[idx]);
        res.new_value = res.accepted ? r.old_value + r.proposal : r.old_value;
        return res;
    endfunction

    // Neighbors mostly cluster around the site value, as in an ordered field.
    function automatic t_site_req random_update();
        t_site_req r;
        int        spread;
        case ($urandom_range(0, 3))
            0: spread = 3;
            1: spread = 20;
            2: spread = 70;
            default: spread = 128;
        endcase
        r.kind = rmsu_pkg::KIND_UPDATE;
        r.old_value = 8'($urandom);
        for (int i = 0; i < rmsu_pkg::NB_COUNT; i++)
            r.nb[i] = 8'(r.old_value + $urandom_range(0, 2 * spread) - spread);
        if ($urandom_range(0, 1))
            r.proposal = 8'($urandom_range(0, 8) - 4);
        else
            r.proposal = 8'($urandom);
        r.chance = 8'($urandom);
        r.tab_addr = 8'($urandom);
        r.tab_data = 8'($urandom);
        return r;
    endfunction

    function automatic t_site_req update_item(input logic [7:0] old_value,
                                              input logic [47:0] nbs,
                                              input logic [7:0] proposal,
                                              input logic [7:0] chance);
        t_site_req r;
        r = random_update();
        r.old_value = old_value;
        r.nb = nbs;
        r.proposal = proposal;
        r.chance = chance;
        return r;
    endfunction

    function automatic t_site_req load_item(input logic [7:0] addr, input logic [7:0] data);
        t_site_req r;
        r = random_update();
        r.kind = rmsu_pkg::KIND_LOAD;
        r.tab_addr = addr;
        r.tab_data = data;
        return r;
    endfunction

    task automatic report_error(input string what);
        error_count++;
        $display("%0t ns: %s", $time, what);
    endtask

    // Called at a rising edge; returns at the edge where the request is taken,
    // leaving tvalid high so that back-to-back requests need no extra step.
    task automatic drive_item(input t_site_req r);
        int gap;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.kind;
        s_axis_tdata  <= {r.tab_data, r.tab_addr, r.chance, r.proposal, r.nb, r.old_value};
        do @(posedge i_clk); while (!s_axis_tready);
        if (r.kind == rmsu_pkg::KIND_LOAD) begin
            accept_thresh[r.tab_addr] = r.tab_data;
            thresh_loaded[r.tab_addr] = 1'b1;
        end else begin
            pending_sites.push_back(metropolis_decide(r));
        end
    endtask

    // An uphill update must never read an entry that was never loaded, so one
    // is loaded first where needed.
    task automatic send_site(input t_site_req r);
        logic [7:0] idx;
        if (r.kind == rmsu_pkg::KIND_UPDATE) begin
            idx = uphill_index(r);
            if (idx != 8'd0 && !thresh_loaded[idx])
                drive_item(load_item(idx, 8'($urandom)));
        end
        drive_item(r);
    endtask

    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        while (pending_sites.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_directed_cases();
        send_site(load_item(8'hFF, 8'hFF));
        send_site(load_item(8'h00, 8'hAA));
        send_site(load_item(8'h02, 8'h00));
        send_site(load_item(8'h06, 8'hFF));
        // Proposal of zero: no change in action.
        send_site(update_item(8'h00, 48'h0, 8'h00, 8'h00));
        // Half-turn against six equal neighbors: change 768, index saturates.
        send_site(update_item(8'h00, 48'h0, 8'h80, 8'hFE));
        send_site(update_item(8'h00, 48'h0, 8'h80, 8'hFF));
        // Candidate wraps past 255 toward the neighbors: downhill.
        send_site(update_item(8'hFF, 48'h0, 8'h01, 8'h00));
        // All fields at their maximum: change of six.
        send_site(update_item(8'hFF, {6{8'hFF}}, 8'hFF, 8'hFF));
        send_site(update_item(8'hFF, {6{8'hFF}}, 8'hFF, 8'hFE));
        // Smallest uphill step against a zero threshold.
        send_site(update_item(8'h00, {{5{8'h01}}, 8'h00}, 8'h02, 8'h00));
        send_site(update_item(8'h80, {8'h00, 8'hFF, 8'h7F, 8'h81, 8'h80, 8'h01},
                              8'h7F, 8'h00));
        send_site(load_item(8'hFF, 8'h00));
        send_site(update_item(8'h00, 48'h0, 8'h80, 8'h00));
    endtask

    task automatic test_random_traffic(input int count);
        t_site_req  r;
        logic [7:0] data;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 12) begin
                case ($urandom_range(0, 3))
                    0: data = 8'h00;
                    1: data = 8'hFF;
                    default: data = 8'($urandom);
                endcase
                r = load_item(8'($urandom), data);
            end else begin
                r = random_update();
            end
            send_site(r);
        end
    endtask

    task automatic test_full_rate(input int count);
        tx_idle_on = 1'b0;
        rx_stall_on = 1'b0;
        test_random_traffic(count);
        tx_idle_on = 1'b1;
        rx_stall_on = 1'b1;
    endtask

    always @(posedge i_clk) begin
        if (rx_hold == 0 && rx_stall_on && $urandom_range(0, 3) == 0)
            rx_hold = pick_gap();
        if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_site_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_sites.size() == 0) begin
                report_error($sformatf("unexpected result: expected none, actual %h",
                                       m_axis_tdata));
            end else begin
                want = pending_sites.pop_front();
                if (m_axis_tdata[7:0] !== want.new_value)
                    report_error($sformatf("new_value: expected %h, actual %h",
                                           want.new_value, m_axis_tdata[7:0]));
                if (m_axis_tdata[8] !== want.accepted)
                    report_error($sformatf("accepted: expected %b, actual %b",
                                           want.accepted, m_axis_tdata[8]));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("%0t ns: no request moved for %0d cycles", $time, IDLE_LIMIT);
            $display("ring_metropolis_site_update_core_test NOT OK");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        drain_pipeline();
        test_random_traffic(400);
        test_full_rate(200);
        drain_pipeline();
        test_random_traffic(400);
        drain_pipeline();
        if (error_count == 0)
            $display("ring_metropolis_site_update_core_test OK");
        else
            $display("ring_metropolis_site_update_core_test NOT OK");
        $finish;
    end

endmodule
